>>> src/bsftc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsftc_pkg: shared types and constants
// Payload structs, file type codes, register indexes, byte constants and a saturating increment.
// ----------------------------------------------------------------------------
package bsftc_pkg;

   localparam int CNT_W             = 11;
   localparam int MAX_BYTES_DEFAULT = 1024;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic [CNT_W-1:0] NEWLINE_THRESHOLD_RESET = CNT_W'(1);
   localparam logic [CNT_W-1:0] SPACE_THRESHOLD_RESET   = CNT_W'(3);

   localparam logic [7:0] BYTE_NUL   = 8'h00;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_FE    = 8'hFE;
   localparam logic [7:0] BYTE_FF    = 8'hFF;
   localparam logic [7:0] BYTE_EF    = 8'hEF;
   localparam logic [7:0] BYTE_BB    = 8'hBB;
   localparam logic [7:0] BYTE_BF    = 8'hBF;

   typedef enum logic [0:0] {
      CSR_NEWLINE_THRESHOLD = 1'b0,
      CSR_SPACE_THRESHOLD   = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      FT_UNKNOWN = 3'd0,
      FT_ASCII   = 3'd1,
      FT_UTF8    = 3'd2,
      FT_UNICODE = 3'd3,
      FT_BINARY  = 3'd4
   } file_type_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
      logic       empty_stream;
   } req_type;

   typedef struct packed {
      file_type_type    file_type;
      logic [CNT_W-1:0] newline_hits;
      logic [CNT_W-1:0] space_hits;
   } rsp_type;

   typedef struct packed {
      logic    done;
      rsp_type data;
   } verdict_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] count,
                                                input logic inc);
      logic [CNT_W-1:0] result;
      result = count;
      if (inc && (count != CNT_MAX)) begin
         result = count + CNT_W'(1);
      end
      return result;
   endfunction

endpackage

>>> src/byte_stream_file_type_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_file_type_classifier: file type sniffer
// Feed the first bytes of a file one per transaction on req_; the byte that
// carries last_byte (or a transaction with empty_stream) ends the stream and
// produces one result transaction on rsp_ with the file type and hit counts.
// Bytes past MAX_BYTES are not classified but last_byte on them still ends
// the stream.
// Throughput: one byte per cycle while req_stall is low. The result is registered:
// it is valid the cycle after the final byte is accepted and sits in the output register.
// When rsp_stall holds a waiting result, req_stall is raised and no further
// byte is taken until the result leaves; with no result waiting the input
// never stalls.
// csr_ writes set the newline and space thresholds; write only when idle.
// Reset (synchronous) clears the stream state, drops any pending result and
// restores the thresholds to 1 and 3.
// ----------------------------------------------------------------------------
module byte_stream_file_type_classifier #(
   parameter int MAX_BYTES = bsftc_pkg::MAX_BYTES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  bsftc_pkg::req_type          req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bsftc_pkg::rsp_type          rsp_data,
   input  logic                        csr_write_en,
   input  bsftc_pkg::csr_index_type    csr_index,
   input  logic [bsftc_pkg::CNT_W-1:0] csr_data
);
   import bsftc_pkg::*;

   logic [CNT_W-1:0] newline_threshold_ff, space_threshold_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;
   logic             req_fire, out_free;
   verdict_type      verdict;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !out_free;
   assign req_fire  = req_valid && out_free;

   bsftc_core #(
      .MAX_BYTES(MAX_BYTES)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .accept            (req_fire),
      .item              (req_data),
      .newline_threshold (newline_threshold_ff),
      .space_threshold   (space_threshold_ff),
      .verdict           (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         newline_threshold_ff <= NEWLINE_THRESHOLD_RESET;
         space_threshold_ff   <= SPACE_THRESHOLD_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_NEWLINE_THRESHOLD: newline_threshold_ff <= csr_data;
            CSR_SPACE_THRESHOLD:   space_threshold_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = verdict.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (verdict.done) begin
         rsp_data_ff <= verdict.data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // empty stream gives an unknown result with no hits
   a_empty_unknown: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.empty_stream |=>
         rsp_valid && (rsp_data.file_type == FT_UNKNOWN) &&
         (rsp_data.newline_hits == '0) && (rsp_data.space_hits == '0))
      else $error("empty stream did not give unknown");

   // a byte that does not end the stream gives no result
   a_mid_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_data.last_byte && !req_data.empty_stream |=> !rsp_valid)
      else $error("result without end of stream");

   // hit counts only accompany a count-based verdict
   a_hits_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.newline_hits != '0) || (rsp_data.space_hits != '0)) |->
         (rsp_data.file_type == FT_UNICODE) || (rsp_data.file_type == FT_BINARY))
      else $error("hit counts on a non-counted verdict");

endmodule

>>> src/bsftc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsftc_core: per-stream scan state and verdict
// Tracks leading bytes, control bytes and NUL-adjacent space/newline hits,
// and forms the file type when a stream ends.
// ----------------------------------------------------------------------------
module bsftc_core #(
   parameter int MAX_BYTES = bsftc_pkg::MAX_BYTES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  bsftc_pkg::req_type          item,
   input  logic [bsftc_pkg::CNT_W-1:0] newline_threshold,
   input  logic [bsftc_pkg::CNT_W-1:0] space_threshold,
   output bsftc_pkg::verdict_type      verdict
);
   import bsftc_pkg::*;

   localparam int SEEN_W = $clog2(MAX_BYTES + 1);
   localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_BYTES);

   logic [7:0]        previous_ff, previous_in;
   logic [7:0]        held_ff, held_in;
   logic              held_valid_ff, held_valid_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [7:0]        lead_ff [3];
   logic [7:0]        lead_in [3];
   logic              control_ff, control_in;
   logic [CNT_W-1:0]  newline_ff, newline_in;
   logic [CNT_W-1:0]  space_ff, space_in;

   logic             take, judge1, nul1, nul2;
   logic [7:0]       b;
   logic [CNT_W-1:0] newline_fin, space_fin;
   logic             is_ctrl;
   file_type_type    ftype;

   always_comb begin
      b       = item.byte_value;
      take    = seen_ff < SEEN_MAX;
      judge1  = take && held_valid_ff;
      nul1    = (previous_ff == BYTE_NUL) || (b == BYTE_NUL);
      is_ctrl = (b < BYTE_SPACE) && (b != BYTE_TAB) && (b != BYTE_LF) && (b != BYTE_CR);

      previous_in   = judge1 ? held_ff : previous_ff;
      held_in       = take ? b : held_ff;
      held_valid_in = take || held_valid_ff;
      seen_in       = take ? seen_ff + SEEN_W'(1) : seen_ff;
      control_in    = control_ff || (take && is_ctrl);
      lead_in       = lead_ff;
      if (take && (seen_ff < SEEN_W'(3))) begin
         lead_in[seen_ff[1:0]] = b;
      end
      space_in   = sat_inc(space_ff, judge1 && nul1 &&
                           ((held_ff == BYTE_SPACE) || (held_ff == BYTE_TAB)));
      newline_in = sat_inc(newline_ff, judge1 && nul1 && (held_ff == BYTE_LF));

      // end of stream: judge the held byte with FF after it
      nul2        = previous_in == BYTE_NUL;
      space_fin   = sat_inc(space_in, held_valid_in && nul2 &&
                            ((held_in == BYTE_SPACE) || (held_in == BYTE_TAB)));
      newline_fin = sat_inc(newline_in, held_valid_in && nul2 && (held_in == BYTE_LF));

      verdict.data.newline_hits = '0;
      verdict.data.space_hits   = '0;
      if (item.empty_stream || (seen_in == '0)) begin
         ftype = FT_UNKNOWN;
      end else if ((seen_in >= SEEN_W'(2)) &&
                   (((lead_in[0] == BYTE_FE) && (lead_in[1] == BYTE_FF)) ||
                    ((lead_in[0] == BYTE_FF) && (lead_in[1] == BYTE_FE)))) begin
         ftype = FT_UNICODE;
      end else if ((seen_in >= SEEN_W'(3)) && (lead_in[0] == BYTE_EF) &&
                   (lead_in[1] == BYTE_BB) && (lead_in[2] == BYTE_BF)) begin
         ftype = FT_UTF8;
      end else if (!control_in) begin
         ftype = FT_ASCII;
      end else begin
         verdict.data.newline_hits = newline_fin;
         verdict.data.space_hits   = space_fin;
         if ((newline_fin > newline_threshold) && (space_fin > space_threshold)) begin
            ftype = FT_UNICODE;
         end else begin
            ftype = FT_BINARY;
         end
      end
      verdict.data.file_type = ftype;
      verdict.done = accept && (item.last_byte || item.empty_stream);
   end

   always_ff @(posedge clock) begin
      if (reset || verdict.done) begin
         previous_ff   <= BYTE_FF;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         seen_ff       <= '0;
         lead_ff       <= '{default: '0};
         control_ff    <= 1'b0;
         newline_ff    <= '0;
         space_ff      <= '0;
      end else if (accept) begin
         previous_ff   <= previous_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         seen_ff       <= seen_in;
         lead_ff       <= lead_in;
         control_ff    <= control_in;
         newline_ff    <= newline_in;
         space_ff      <= space_in;
      end
   end

endmodule

>>> dv/tb_byte_stream_file_type_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_stream_file_type_classifier: self-checking testbench
// Streams of bytes go in through a driver with random gaps, and verdicts come
// out through a monitor with random stalls. Each accepted transaction goes
// through a cycle-free model of the sniffer: byte-order marks, control-byte
// scan, NUL-adjacent space and newline counts, threshold compare and the
// byte limit. Each verdict is compared with the oldest prediction. Thresholds
// change between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_byte_stream_file_type_classifier;
   import bsftc_pkg::*;

   localparam int MAX_BYTES = MAX_BYTES_DEFAULT;

   typedef enum int {
      STREAM_UTF16_TEXT,
      STREAM_ASCII_TEXT,
      STREAM_UTF16_MARK,
      STREAM_UTF8_MARK,
      STREAM_NEAR_MARK,
      STREAM_BINARY,
      STREAM_ABORTED,
      STREAM_EMPTY
   } stream_kind_type;

   logic             clock        = 1'b0;
   logic             reset        = 1'b1;
   logic             req_valid    = 1'b0;
   logic             req_stall;
   req_type          req_data     = '0;
   logic             rsp_valid;
   logic             rsp_stall    = 1'b0;
   rsp_type          rsp_data;
   logic             csr_write_en = 1'b0;
   csr_index_type    csr_index    = CSR_NEWLINE_THRESHOLD;
   logic [CNT_W-1:0] csr_data     = '0;

   // sniffer model state
   logic [CNT_W-1:0] nl_limit;
   logic [CNT_W-1:0] sp_limit;
   logic [7:0]       prior_byte;
   logic [7:0]       held_char;
   logic             held_live;
   int               byte_count;
   logic [23:0]      lead_bytes;
   logic             saw_control;
   logic [CNT_W-1:0] nl_hits;
   logic [CNT_W-1:0] sp_hits;

   req_type     byte_queue[$];
   rsp_type     verdicts_due[$];
   logic [7:0]  draft[$];
   rsp_type     next_verdict;
   rsp_type     want;
   int          items_queued  = 0;
   int          bytes_taken   = 0;
   int          fail_count    = 0;
   int          verdict_tally[0:4] = '{default: 0};
   int          gap_left      = 0;
   int          stall_left    = 0;
   bit          quiet         = 1'b0;

   byte_stream_file_type_classifier #(.MAX_BYTES(MAX_BYTES)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #6 clock = ~clock;

   function automatic void clear_sniffer();
      prior_byte  = BYTE_FF;
      held_char   = '0;
      held_live   = 1'b0;
      byte_count  = 0;
      lead_bytes  = '0;
      saw_control = 1'b0;
      nl_hits     = '0;
      sp_hits     = '0;
   endfunction

   function automatic void judge_held(input logic [7:0] next_char);
      logic nul_near;
      nul_near = (prior_byte == BYTE_NUL) || (next_char == BYTE_NUL);
      if ((held_char == BYTE_SPACE || held_char == BYTE_TAB) && nul_near &&
          sp_hits != CNT_MAX) begin
         sp_hits = sp_hits + 1'b1;
      end
      if (held_char == BYTE_LF && nul_near && nl_hits != CNT_MAX) begin
         nl_hits = nl_hits + 1'b1;
      end
      prior_byte = held_char;
      held_live  = 1'b0;
   endfunction

   function automatic bit sniff_byte(input req_type item, output rsp_type verdict);
      logic [7:0] b;
      verdict = '0;
      b = item.byte_value;
      if (item.empty_stream) begin
         clear_sniffer();
         verdict.file_type = FT_UNKNOWN;
         return 1'b1;
      end
      if (byte_count < MAX_BYTES) begin
         if (held_live) begin
            judge_held(b);
         end
         held_char = b;
         held_live = 1'b1;
         if (byte_count < 3) begin
            lead_bytes[23 - 8*byte_count -: 8] = b;
         end
         if (b < BYTE_SPACE && b != BYTE_TAB && b != BYTE_LF && b != BYTE_CR) begin
            saw_control = 1'b1;
         end
         byte_count++;
      end
      if (!item.last_byte) begin
         return 1'b0;
      end
      if (held_live) begin
         judge_held(BYTE_FF);
      end
      if (byte_count == 0) begin
         verdict.file_type = FT_UNKNOWN;
      end else if (byte_count >= 2 &&
                   ((lead_bytes[23:16] == BYTE_FE && lead_bytes[15:8] == BYTE_FF) ||
                    (lead_bytes[23:16] == BYTE_FF && lead_bytes[15:8] == BYTE_FE))) begin
         verdict.file_type = FT_UNICODE;
      end else if (byte_count >= 3 && lead_bytes == {BYTE_EF, BYTE_BB, BYTE_BF}) begin
         verdict.file_type = FT_UTF8;
      end else if (!saw_control) begin
         verdict.file_type = FT_ASCII;
      end else begin
         verdict.newline_hits = nl_hits;
         verdict.space_hits   = sp_hits;
         verdict.file_type    = (nl_hits > nl_limit && sp_hits > sp_limit) ?
                                FT_UNICODE : FT_BINARY;
      end
      clear_sniffer();
      return 1'b1;
   endfunction

   function automatic void add_item(input logic [7:0] value, input logic last,
                                    input logic empty);
      req_type item;
      item.byte_value   = value;
      item.last_byte    = last;
      item.empty_stream = empty;
      byte_queue.push_back(item);
      items_queued++;
   endfunction

   function automatic void send_draft();
      for (int i = 0; i < draft.size(); i++) begin
         add_item(draft[i], i == draft.size() - 1, 1'b0);
      end
      draft.delete();
   endfunction

   function automatic logic [7:0] text_char();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 4) return BYTE_SPACE;
      if (pick < 5) return BYTE_TAB;
      if (pick < 8) return BYTE_LF;
      if (pick < 9) return BYTE_CR;
      if (pick < 10) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(8'h21, 8'h7E));
   endfunction

   function automatic void random_stream();
      stream_kind_type kind;
      int              pick;
      int              len;
      bit              big_end;
      pick = $urandom_range(0, 99);
      len  = $urandom_range(1, 24);
      if (pick < 38)      kind = STREAM_UTF16_TEXT;
      else if (pick < 52) kind = STREAM_ASCII_TEXT;
      else if (pick < 60) kind = STREAM_UTF16_MARK;
      else if (pick < 67) kind = STREAM_UTF8_MARK;
      else if (pick < 74) kind = STREAM_NEAR_MARK;
      else if (pick < 88) kind = STREAM_BINARY;
      else if (pick < 95) kind = STREAM_ABORTED;
      else                kind = STREAM_EMPTY;
      draft.delete();
      case (kind)
         STREAM_UTF16_TEXT: begin
            big_end = 1'($urandom_range(0, 1));
            for (int i = 0; i < len; i++) begin
               if (big_end) draft.push_back(BYTE_NUL);
               draft.push_back(text_char());
               if (!big_end) draft.push_back(BYTE_NUL);
            end
            if ($urandom_range(0, 7) == 0) draft.pop_back();
         end
         STREAM_ASCII_TEXT: begin
            for (int i = 0; i < len; i++) begin
               draft.push_back(($urandom_range(0, 5) == 0) ? text_char() :
                               8'($urandom_range(8'h20, 8'hFF)));
            end
         end
         STREAM_UTF16_MARK, STREAM_UTF8_MARK: begin
            if (kind == STREAM_UTF8_MARK) begin
               draft.push_back(BYTE_EF);
               draft.push_back(BYTE_BB);
               draft.push_back(BYTE_BF);
            end else if ($urandom_range(0, 1)) begin
               draft.push_back(BYTE_FE);
               draft.push_back(BYTE_FF);
            end else begin
               draft.push_back(BYTE_FF);
               draft.push_back(BYTE_FE);
            end
            for (int i = $urandom_range(0, 8); i > 0; i--) begin
               draft.push_back(8'($urandom_range(0, 255)));
            end
         end
         STREAM_NEAR_MARK: begin
            case ($urandom_range(0, 5))
               0: begin draft.push_back(BYTE_EF); draft.push_back(BYTE_BB); end
               1: draft.push_back(BYTE_EF);
               2: draft.push_back(BYTE_FE);
               3: draft.push_back(BYTE_FF);
               4: begin draft.push_back(BYTE_FF); draft.push_back(BYTE_FF); end
               default: begin draft.push_back(BYTE_FE); draft.push_back(BYTE_FE); end
            endcase
            for (int i = $urandom_range(0, 3); i > 0; i--) begin
               draft.push_back(8'($urandom_range(0, 255)));
            end
         end
         STREAM_BINARY: begin
            for (int i = 0; i < len; i++) begin
               draft.push_back(($urandom_range(0, 3) == 0) ? BYTE_NUL :
                               8'($urandom_range(0, 255)));
            end
         end
         default: begin
            // aborted and empty streams: aborted ones send some bytes first, then an empty-stream transaction
            if (kind == STREAM_ABORTED) begin
               for (int i = 0; i < len; i++) begin
                  add_item(($urandom_range(0, 1)) ? BYTE_NUL : text_char(), 1'b0, 1'b0);
               end
            end
            add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
         end
      endcase
      send_draft();
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [CNT_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_NEWLINE_THRESHOLD) nl_limit = value;
      else sp_limit = value;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (byte_queue.size() != 0 || req_valid || verdicts_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_phase(input int count);
      int goal;
      goal = items_queued + count;
      while (items_queued < goal) random_stream();
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            bytes_taken++;
            if (sniff_byte(req_data, next_verdict)) verdicts_due.push_back(next_verdict);
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
               gap_left = $urandom_range(1, 18) - 1;
               req_valid <= 1'b0;
            end else if (byte_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= byte_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdicts_due.size() == 0) begin
               $error("unexpected result transaction: file_type %0d", rsp_data.file_type);
               fail_count++;
            end else begin
               want = verdicts_due.pop_front();
               verdict_tally[int'(want.file_type)]++;
               if (rsp_data.file_type !== want.file_type) begin
                  $error("file_type: expected %0d, got %0d", want.file_type,
                         rsp_data.file_type);
                  fail_count++;
               end
               if (rsp_data.newline_hits !== want.newline_hits) begin
                  $error("newline_hits: expected %0d, got %0d", want.newline_hits,
                         rsp_data.newline_hits);
                  fail_count++;
               end
               if (rsp_data.space_hits !== want.space_hits) begin
                  $error("space_hits: expected %0d, got %0d", want.space_hits,
                         rsp_data.space_hits);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      clear_sniffer();
      nl_limit = NEWLINE_THRESHOLD_RESET;
      sp_limit = SPACE_THRESHOLD_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed, reset thresholds
      add_item(BYTE_FF, 1'b1, 1'b1);
      add_item(BYTE_FE, 1'b0, 1'b0);
      add_item(BYTE_FF, 1'b1, 1'b0);
      add_item(BYTE_FF, 1'b0, 1'b0);
      add_item(BYTE_FE, 1'b1, 1'b0);
      add_item(BYTE_EF, 1'b0, 1'b0);
      add_item(BYTE_BB, 1'b0, 1'b0);
      add_item(BYTE_BF, 1'b1, 1'b0);
      add_item(BYTE_TAB, 1'b0, 1'b0);
      add_item(BYTE_CR, 1'b0, 1'b0);
      add_item(BYTE_LF, 1'b1, 1'b0);
      add_item(8'h41, 1'b0, 1'b0);
      add_item(BYTE_SPACE, 1'b0, 1'b0);
      add_item(8'h00, 1'b0, 1'b1);
      for (int i = 0; i < 6; i++) begin
         draft.push_back((i == 1 || i == 3) ? BYTE_LF : BYTE_SPACE);
         draft.push_back(BYTE_NUL);
      end
      send_draft();
      random_phase(40);
      drain();

      // zero thresholds
      write_csr(CSR_NEWLINE_THRESHOLD, '0);
      write_csr(CSR_SPACE_THRESHOLD, '0);
      random_phase(80);
      drain();

      write_csr(CSR_NEWLINE_THRESHOLD, 11'd1024);
      write_csr(CSR_SPACE_THRESHOLD, 11'd1023);
      random_phase(70);
      drain();

      write_csr(CSR_SPACE_THRESHOLD, CNT_W'($urandom_range(0, 8)));
      write_csr(CSR_NEWLINE_THRESHOLD, CNT_W'($urandom_range(0, 8)));
      random_phase(80);
      drain();

      quiet = 1'b1;
      write_csr(CSR_NEWLINE_THRESHOLD, CNT_W'($urandom_range(0, 4)));
      write_csr(CSR_SPACE_THRESHOLD, CNT_W'($urandom_range(0, 6)));
      random_phase(80);
      drain();
      repeat (8) @(posedge clock);

      if (verdicts_due.size() != 0) begin
         $error("%0d verdicts never arrived", verdicts_due.size());
         fail_count++;
      end
      $display("Sent %0d transactions (%0d accepted) over five threshold settings.",
               items_queued, bytes_taken);
      $display("Verdicts: unknown %0d, ascii %0d, utf8 %0d, unicode %0d, binary %0d.",
               verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
               verdict_tally[4]);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
